// ----- src/wcpd_pkg.sv -----
// Package for the waveform column peak decimator.
// Sizes, register map, color classes, controller states and the
// command/status bundles used by the modules. No dependencies.
`default_nettype none
package wcpd_pkg;

  localparam int SAMPLE_DEPTH = 65536;
  localparam int COLUMNS      = 256;
  localparam int BAR_HEIGHT   = 128;
  localparam int TOP_OFFSET   = 16;

  localparam int FULL_SCALE_SH = 15;  // full scale 32768
  localparam int CURSOR_WIDTH  = 3;

  localparam int ADDR_W  = $clog2(SAMPLE_DEPTH);
  localparam int COL_SH  = $clog2(COLUMNS);
  localparam int POS_W   = 17;
  localparam int ROW_W   = 12;
  localparam int PROD_W  = 26;

  localparam int HALF_HEIGHT  = BAR_HEIGHT / 2;
  localparam int CENTER_ROW   = TOP_OFFSET + HALF_HEIGHT;
  localparam int BOTTOM_LIMIT = TOP_OFFSET + BAR_HEIGHT;

  localparam logic [7:0] CURSOR_RESET = 8'd128;

  typedef enum logic [2:0] {
    REG_VIEW_START    = 3'd0,
    REG_VIEW_LENGTH   = 3'd1,
    REG_SAMPLE_COUNT  = 3'd2,
    REG_TRIM_START    = 3'd3,
    REG_TRIM_END      = 3'd4,
    REG_CURSOR_COLUMN = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    CLASS_NORMAL = 2'd0,
    CLASS_TRIM   = 2'd1,
    CLASS_CURSOR = 2'd2
  } color_class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_SCALE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [15:0]      view_start;
    logic [POS_W-1:0] view_length;
    logic [POS_W-1:0] sample_count;
    logic [POS_W-1:0] trim_start;
    logic [POS_W-1:0] trim_end;
    logic [7:0]       cursor_column;
  } cfg_t;

  typedef struct packed {
    logic mem_write;
    logic load;
    logic calc_last;
    logic read;
    logic scale;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic render_ok;
    logic scan_more;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- src/waveform_column_peak_decimator.sv -----
// Waveform column peak decimator: sample memory plus per-column min/max
// reduction. Top level joins wcpd_regs, wcpd_ctrl and wcpd_dp (wcpd_pkg).
//
// Usage:
//   Input word: start with in_command/in_address/in_sample_value/in_column,
//   taken at an edge where start is high and busy is low.
//   A write word (in_command 0) stores one sample and
//   leaves busy low, so writes can stream one per cycle.
//   A render word (in_command 1) maps in_column to its sample span, scans
//   the span one memory read per cycle and returns one result word.
//   Render busy time rises with span, span = clamped last - first
//   samples (about view_length / 256); the single memory read port sets it.
//   The result word shows on the out_ ports for exactly one cycle with
//   out_valid high, in the first cycle with busy low; the receiver cannot stall.
//   A render with zero view length, zero sample count or a column off the
//   display returns no word and leaves busy low.
//   Registers are written over the APB-style port; the user must write them only while idle (not enforced).
//   Reset clears the registers (cursor column to 128) and the controller;
//   the sample memory is not cleared and must be written before use.
`default_nettype none
module waveform_column_peak_decimator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_command,
  input  wire logic [15:0]        in_address,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic [7:0]         in_column,
  output logic                    out_valid,
  output logic [7:0]              out_column_out,
  output logic [7:0]              out_top_row,
  output logic [7:0]              out_bottom_row,
  output logic signed [15:0]      out_peak_low,
  output logic [14:0]             out_peak_high,
  output logic                    out_draw_bar,
  output logic [1:0]              out_color_class,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  wcpd_pkg::cfg_t       cfg;
  wcpd_pkg::dp_cmd_t    cmd;
  wcpd_pkg::dp_status_t status;

  wcpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wcpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  wcpd_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .in_address      (in_address),
    .in_sample_value (in_sample_value),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_column_out  (out_column_out),
    .out_top_row     (out_top_row),
    .out_bottom_row  (out_bottom_row),
    .out_peak_low    (out_peak_low),
    .out_peak_high   (out_peak_high),
    .out_draw_bar    (out_draw_bar),
    .out_color_class (out_color_class)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result issued while still busy");

  a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_row <= out_bottom_row) &&
                  (out_draw_bar == (out_bottom_row > out_top_row)))
    else $error("bar rows out of order or draw flag mismatch");

  a_render_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result appeared right after an accepted word");

endmodule
`default_nettype wire

// ----- src/wcpd_regs.sv -----
// Configuration register file behind the APB-style port.
// Depends on wcpd_pkg for the register map and cfg_t.
`default_nettype none
module wcpd_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output wcpd_pkg::cfg_t         cfg
);

  wcpd_pkg::cfg_t     cfg_r, cfg_nxt;
  wcpd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = wcpd_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        wcpd_pkg::REG_VIEW_START:    cfg_nxt.view_start    = pwdata[15:0];
        wcpd_pkg::REG_VIEW_LENGTH:   cfg_nxt.view_length   = pwdata[16:0];
        wcpd_pkg::REG_SAMPLE_COUNT:  cfg_nxt.sample_count  = pwdata[16:0];
        wcpd_pkg::REG_TRIM_START:    cfg_nxt.trim_start    = pwdata[16:0];
        wcpd_pkg::REG_TRIM_END:      cfg_nxt.trim_end      = pwdata[16:0];
        wcpd_pkg::REG_CURSOR_COLUMN: cfg_nxt.cursor_column = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      wcpd_pkg::REG_VIEW_START:    prdata = {16'd0, cfg_r.view_start};
      wcpd_pkg::REG_VIEW_LENGTH:   prdata = {15'd0, cfg_r.view_length};
      wcpd_pkg::REG_SAMPLE_COUNT:  prdata = {15'd0, cfg_r.sample_count};
      wcpd_pkg::REG_TRIM_START:    prdata = {15'd0, cfg_r.trim_start};
      wcpd_pkg::REG_TRIM_END:      prdata = {15'd0, cfg_r.trim_end};
      wcpd_pkg::REG_CURSOR_COLUMN: prdata = {24'd0, cfg_r.cursor_column};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r               <= '0;
      cfg_r.cursor_column <= wcpd_pkg::CURSOR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/wcpd_ctrl.sv -----
// Controller state machine: sequences span setup, the memory scan,
// scaling and result emission. Depends on wcpd_pkg.
`default_nettype none
module wcpd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 in_command,
  input  wire wcpd_pkg::dp_status_t status,
  output wcpd_pkg::dp_cmd_t         cmd,
  output logic                      busy
);

  wcpd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wcpd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      wcpd_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (!in_command) begin
            cmd.mem_write = 1'b1;
          end else if (status.render_ok) begin
            cmd.load  = 1'b1;
            state_nxt = wcpd_pkg::ST_LAST;
          end
        end
      end
      wcpd_pkg::ST_LAST: begin
        cmd.calc_last = 1'b1;
        state_nxt     = wcpd_pkg::ST_SCAN;
      end
      wcpd_pkg::ST_SCAN: begin
        // the last read's data folds in at the edge that leaves this state
        if (status.scan_more) begin
          cmd.read = 1'b1;
        end else begin
          state_nxt = wcpd_pkg::ST_SCALE;
        end
      end
      wcpd_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = wcpd_pkg::ST_EMIT;
      end
      wcpd_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = wcpd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = wcpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- src/wcpd_dp.sv -----
// Datapath: sample memory, span arithmetic, min/max accumulation,
// row scaling, clamping and column classing. Depends on wcpd_pkg.
`default_nettype none
module wcpd_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire wcpd_pkg::cfg_t        cfg,
  input  wire wcpd_pkg::dp_cmd_t     cmd,
  output wcpd_pkg::dp_status_t       status,
  input  wire logic [15:0]           in_address,
  input  wire logic signed [15:0]    in_sample_value,
  input  wire logic [7:0]            in_column,
  output logic                       out_valid,
  output logic [7:0]                 out_column_out,
  output logic [7:0]                 out_top_row,
  output logic [7:0]                 out_bottom_row,
  output logic signed [15:0]         out_peak_low,
  output logic [14:0]                out_peak_high,
  output logic                       out_draw_bar,
  output logic [1:0]                 out_color_class
);

  localparam int POS_W = wcpd_pkg::POS_W;
  localparam int ROW_W = wcpd_pkg::ROW_W;
  localparam int PROD_W = wcpd_pkg::PROD_W;

  logic [15:0] mem [wcpd_pkg::SAMPLE_DEPTH];
  logic [15:0] rdata_r;
  logic        rd_valid_r;

  logic [7:0]       col_r;
  logic [POS_W-1:0] first_raw_r, first_r, last_r, s_r;
  logic signed [15:0] lo_r;
  logic [14:0]      hi_r;
  logic [ROW_W-1:0] top_raw_r, bot_raw_r;

  logic [PROD_W-1:0] first_prod, last_prod, hi_prod, lo_prod;
  logic [POS_W-1:0]  first_calc, last_calc;
  logic [15:0]       lo_mag;
  logic signed [15:0] rd_sample;

  logic [ROW_W-1:0] top_c, bot_c;
  logic [8:0]       cursor_hi;
  logic [POS_W-1:0] trim_hi;
  logic [1:0]       class_c;

  // sample memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[in_address[wcpd_pkg::ADDR_W-1:0]] <= in_sample_value;
    end
    if (cmd.read) begin
      rdata_r <= mem[s_r[wcpd_pkg::ADDR_W-1:0]];
    end
  end

  assign status.render_ok = (cfg.view_length != '0) && (cfg.sample_count != '0) &&
                            (11'(in_column) < 11'(wcpd_pkg::COLUMNS));
  assign status.scan_more = (s_r < last_r);

  // column to span: shift stands for the divide by the column count
  assign first_prod = PROD_W'(in_column) * PROD_W'(cfg.view_length);
  assign last_prod  = (PROD_W'(col_r) + PROD_W'(1)) * PROD_W'(cfg.view_length);
  assign first_calc = POS_W'(cfg.view_start) + POS_W'(first_prod >> wcpd_pkg::COL_SH);
  assign last_calc  = POS_W'(cfg.view_start) + POS_W'(last_prod >> wcpd_pkg::COL_SH);

  assign rd_sample = rdata_r;
  assign lo_mag    = 16'd0 - lo_r;
  assign hi_prod   = PROD_W'(hi_r) * PROD_W'(wcpd_pkg::HALF_HEIGHT);
  assign lo_prod   = PROD_W'(lo_mag) * PROD_W'(wcpd_pkg::HALF_HEIGHT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r       <= in_column;
      first_raw_r <= first_calc;
      lo_r        <= '0;
      hi_r        <= '0;
    end else if (rd_valid_r) begin
      if (rd_sample < lo_r) begin
        lo_r <= rd_sample;
      end
      if (!rd_sample[15] && (rd_sample[14:0] > hi_r)) begin
        hi_r <= rd_sample[14:0];
      end
    end
    if (cmd.calc_last) begin
      last_r  <= (last_calc > cfg.sample_count) ? cfg.sample_count : last_calc;
      if (first_raw_r >= cfg.sample_count) begin
        first_r <= cfg.sample_count - POS_W'(1);
        s_r     <= cfg.sample_count - POS_W'(1);
      end else begin
        first_r <= first_raw_r;
        s_r     <= first_raw_r;
      end
    end else if (cmd.read) begin
      s_r <= s_r + POS_W'(1);
    end
    if (cmd.scale) begin
      top_raw_r <= ROW_W'(wcpd_pkg::CENTER_ROW) - ROW_W'(hi_prod >> wcpd_pkg::FULL_SCALE_SH);
      bot_raw_r <= ROW_W'(wcpd_pkg::CENTER_ROW) + ROW_W'(lo_prod >> wcpd_pkg::FULL_SCALE_SH);
    end
  end

  // clamp rows, then widen an empty bar by one row when there is signal
  always_comb begin
    top_c = (top_raw_r < ROW_W'(wcpd_pkg::TOP_OFFSET)) ?
            ROW_W'(wcpd_pkg::TOP_OFFSET) : top_raw_r;
    bot_c = (bot_raw_r > ROW_W'(wcpd_pkg::BOTTOM_LIMIT)) ?
            ROW_W'(wcpd_pkg::BOTTOM_LIMIT) : bot_raw_r;
    if (top_c > bot_c) begin
      top_c = bot_c;
    end
    if ((bot_c == top_c) && ((hi_r != '0) || (lo_r != '0))) begin
      bot_c = top_c + ROW_W'(1);
    end
  end

  assign cursor_hi = 9'(cfg.cursor_column) + 9'(wcpd_pkg::CURSOR_WIDTH);
  assign trim_hi   = (cfg.trim_end == '0) ? cfg.sample_count : cfg.trim_end;

  always_comb begin
    if ((col_r >= cfg.cursor_column) && (9'(col_r) < cursor_hi)) begin
      class_c = wcpd_pkg::CLASS_CURSOR;
    end else if ((first_r < cfg.trim_start) || (first_r >= trim_hi)) begin
      class_c = wcpd_pkg::CLASS_TRIM;
    end else begin
      class_c = wcpd_pkg::CLASS_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_column_out  <= col_r;
      out_top_row     <= top_c[7:0];
      out_bottom_row  <= bot_c[7:0];
      out_peak_low    <= lo_r;
      out_peak_high   <= hi_r;
      out_draw_bar    <= (bot_c > top_c);
      out_color_class <= class_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid_r <= cmd.read;
      out_valid  <= cmd.emit;
    end
  end

endmodule
`default_nettype wire
